// ===== rtl/chrt_pkg.sv =====
// shared types and codes for the client handle request table
// no dependencies; imported by chrt_ctrl, chrt_dpath and the top level
package chrt_pkg;

  // operation codes
  localparam logic OP_ISSUE = 1'b0;
  localparam logic OP_APPLY = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_CONFLICT   = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

  // field widths fixed by the interface
  localparam int HANDLE_W = 5;
  localparam int DATA_W   = 32;

  // controller to datapath commands
  typedef struct packed {
    logic latch;   // capture the input beat
    logic decode;  // classify the item, do issue or request write
    logic key;     // capture own resource key, start the scan
    logic scan;    // compare one entry per cycle
    logic load;    // move the result into the output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic apply_ok;   // apply with a valid handle
    logic scan_done;  // conflict found or last entry checked
    logic out_free;   // output register can take a new beat
  } stat_t;

endpackage

// ===== rtl/client_handle_request_table.sv =====
// top level of the client handle request table
// depends on chrt_pkg, chrt_ctrl and chrt_dpath
//
// usage:
//  - input channel (in_valid / in_stall) carries one request beat: an issue
//    operation appends an entry for resource_key, an apply operation stores
//    request_value under handle and looks for a conflicting client
//  - output channel (out_valid / out_stall) returns exactly one result beat
//    per accepted input beat, in order
//  - sequence: an issue or a rejected apply goes from decode straight to the
//    result hand-off; a valid apply first fetches its own resource key and
//    then scans the table, reading one table entry per cycle from the
//    memories until a conflict is found or the last entry is checked
//  - throughput: one item at a time; in_stall is high from acceptance until
//    the result is in the output register
//  - the output register lets the next beat be accepted while a finished
//    result is still stalled; a new result waits until that one is taken
//  - reset clears the handle count, the issued bits and the output valid;
//    entry contents are written before they are ever read
module client_handle_request_table import chrt_pkg::*; #(
  parameter int MAX_CLIENTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                operation,
  input  logic [DATA_W-1:0]   resource_key,
  input  logic [HANDLE_W-1:0] handle,
  input  logic [DATA_W-1:0]   request_value,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [HANDLE_W-1:0] assigned_handle,
  output logic [DATA_W-1:0]   request_echo,
  output logic [HANDLE_W-1:0] conflict_handle,
  output logic [DATA_W-1:0]   conflict_request,
  output logic [HANDLE_W-1:0] handle_count
);

  cmd_t  cmd;   // controller commands
  stat_t stat;  // datapath status

  // sequencer: accept, decode, key fetch, scan, result hand-off
  chrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table storage, conflict scan and output register
  chrt_dpath #(
    .MAX_CLIENTS (MAX_CLIENTS)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .operation        (operation),
    .resource_key     (resource_key),
    .handle           (handle),
    .request_value    (request_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .assigned_handle  (assigned_handle),
    .request_echo     (request_echo),
    .conflict_handle  (conflict_handle),
    .conflict_request (conflict_request),
    .handle_count     (handle_count)
  );

endmodule

// ===== rtl/chrt_ctrl.sv =====
// sequencing state machine for the client handle request table
// depends on chrt_pkg (cmd_t, stat_t)
module chrt_ctrl import chrt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_KEY,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DECODE;
        end
        S_DECODE: begin
          state <= stat.apply_ok ? S_KEY : S_DONE;
        end
        S_KEY: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.scan_done) state <= S_DONE;
        end
        S_DONE: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall   = (state != S_IDLE);
  assign cmd.latch  = (state == S_IDLE) && in_valid;
  assign cmd.decode = (state == S_DECODE);
  assign cmd.key    = (state == S_KEY);
  assign cmd.scan   = (state == S_SCAN);
  assign cmd.load   = (state == S_DONE) && stat.out_free;

endmodule

// ===== rtl/chrt_dpath.sv =====
// entry storage, scan datapath and output register of the handle table
// depends on chrt_pkg (codes, widths, cmd_t, stat_t)
module chrt_dpath import chrt_pkg::*; #(
  parameter int MAX_CLIENTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic                operation,
  input  logic [DATA_W-1:0]   resource_key,
  input  logic [HANDLE_W-1:0] handle,
  input  logic [DATA_W-1:0]   request_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [HANDLE_W-1:0] assigned_handle,
  output logic [DATA_W-1:0]   request_echo,
  output logic [HANDLE_W-1:0] conflict_handle,
  output logic [DATA_W-1:0]   conflict_request,
  output logic [HANDLE_W-1:0] handle_count
);

  localparam int CNT_W = $clog2(MAX_CLIENTS + 1);
  localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CMP_W = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;

  // entry storage
  logic [DATA_W-1:0]      resource_mem [MAX_CLIENTS];
  logic [DATA_W-1:0]      request_mem  [MAX_CLIENTS];
  logic [MAX_CLIENTS-1:0] issued;
  logic [CNT_W-1:0]       count;

  // captured input beat
  logic                op_q;
  logic [DATA_W-1:0]   key_q;
  logic [HANDLE_W-1:0] hnd_q;
  logic [DATA_W-1:0]   req_q;

  // scan registers
  logic [DATA_W-1:0] res_rd;
  logic [DATA_W-1:0] req_rd;
  logic [IDX_W-1:0]  rd_idx;
  logic [DATA_W-1:0] self_key;

  // pending result
  logic [1:0]          res_status;
  logic [HANDLE_W-1:0] res_assigned;
  logic [DATA_W-1:0]   res_echo;
  logic [HANDLE_W-1:0] res_chandle;
  logic [DATA_W-1:0]   res_creq;

  logic             full;
  logic             bad;
  logic [IDX_W-1:0] self_idx;
  logic [IDX_W-1:0] cnt_idx;
  logic [CNT_W-1:0] count_next;
  logic             last;
  logic             match;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] hit_handle;

  assign full       = (count == CNT_W'(MAX_CLIENTS));
  assign bad        = (hnd_q == '0) || (CMP_W'(hnd_q) > CMP_W'(count));
  assign self_idx   = IDX_W'(hnd_q - 1'b1);
  assign cnt_idx    = IDX_W'(count);
  assign count_next = count + 1'b1;
  assign last       = (CNT_W'(rd_idx) == (count - 1'b1));
  assign match      = (rd_idx != self_idx) && issued[rd_idx] && (res_rd == self_key);
  assign hit_handle = CNT_W'(rd_idx) + 1'b1;

  assign stat.apply_ok  = (op_q == OP_APPLY) && !bad;
  assign stat.scan_done = match || last;
  assign stat.out_free  = !out_valid || !out_stall;

  // read address: own entry at decode, entry 0 at key, then walk upward
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_idx + 1'b1;
    if (cmd.decode) begin
      rd_en   = stat.apply_ok;
      rd_addr = self_idx;
    end else if (cmd.key) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd.scan) begin
      rd_en   = !last;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q  <= operation;
      key_q <= resource_key;
      hnd_q <= handle;
      req_q <= request_value;
    end
  end

  // memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      if (op_q == OP_ISSUE) begin
        if (!full) begin
          resource_mem[cnt_idx] <= key_q;
          request_mem[cnt_idx]  <= '0;
        end
      end else if (!bad) begin
        request_mem[self_idx] <= req_q;
      end
    end
    if (rd_en) begin
      res_rd <= resource_mem[rd_addr];
      req_rd <= request_mem[rd_addr];
      rd_idx <= rd_addr;
    end
    if (cmd.key) self_key <= res_rd;
  end

  // count and issued bits
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      issued <= '0;
    end else if (cmd.decode) begin
      if (op_q == OP_ISSUE) begin
        if (!full) begin
          issued[cnt_idx] <= 1'b0;
          count           <= count_next;
        end
      end else if (!bad) begin
        issued[self_idx] <= 1'b1;
      end
    end
  end

  // result assembly
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      res_assigned <= '0;
      res_echo     <= '0;
      res_chandle  <= '0;
      res_creq     <= '0;
      if (op_q == OP_ISSUE) begin
        if (!full) begin
          res_status   <= ST_OK;
          res_assigned <= HANDLE_W'(count_next);
        end else begin
          res_status <= ST_FULL;
        end
      end else if (bad) begin
        res_status <= ST_BAD_HANDLE;
      end else begin
        res_status <= ST_OK;
        res_echo   <= req_q;
      end
    end else if (cmd.scan && match) begin
      res_status  <= ST_CONFLICT;
      res_chandle <= HANDLE_W'(hit_handle);
      res_creq    <= req_rd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status           <= res_status;
      assigned_handle  <= res_assigned;
      request_echo     <= res_echo;
      conflict_handle  <= res_chandle;
      conflict_request <= res_creq;
      handle_count     <= HANDLE_W'(count);
    end
  end

endmodule
